// ----- hw/rtl/pcps_pkg.sv -----
// ----------------------------------------------------------------------------
// pcps_pkg
// Shared types, constants and the saturation helper for the closed-loop step.
// ----------------------------------------------------------------------------
package pcps_pkg;

  localparam int ACC_W = 52;   // wide accumulator for summed Q16.16 products

  localparam logic signed [31:0] ONE_Q      = 32'sh0001_0000;
  localparam logic signed [31:0] TWO_Q      = 32'sh0002_0000;
  localparam logic signed [31:0] TOL_Q      = 32'sd655;
  localparam logic signed [31:0] INV_TWO_PI = 32'sd683565276;

  // configuration register indexes
  localparam logic [2:0] REG_SETPOINT   = 3'd0;
  localparam logic [2:0] REG_GAIN_NOW   = 3'd1;
  localparam logic [2:0] REG_GAIN_LAST  = 3'd2;
  localparam logic [2:0] REG_GAIN_OLDER = 3'd3;
  localparam logic [2:0] REG_PLANT_A    = 3'd4;
  localparam logic [2:0] REG_PLANT_B    = 3'd5;
  localparam logic [2:0] REG_PLANT_C    = 3'd6;
  localparam logic [2:0] REG_PLANT_D    = 3'd7;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } sat_t;

  function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
    sat_t r;
    if (v > ACC_W'(signed'(32'sh7FFF_FFFF))) begin
      r.val  = 32'sh7FFF_FFFF;
      r.clip = 1'b1;
    end else if (v < ACC_W'(signed'(32'sh8000_0000))) begin
      r.val  = 32'sh8000_0000;
      r.clip = 1'b1;
    end else begin
      r.val  = v[31:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/pid_closed_loop_plant_step_core.sv -----
// ----------------------------------------------------------------------------
// pid_closed_loop_plant_step_core
// At most one closed-loop iteration per input beat: incremental PID plus a
// second-order plant with a sine term, Q16.16 with saturation.
// ----------------------------------------------------------------------------
// Each input beat yields one output beat. A restart beat, a beat while the loop
// is stopped, or a beat that finds the stop condition already met passes only
// through the accepting cycle and the entry check. A full step runs the
// accepting cycle, one entry check, nine products on the single shared
// multiplier (issue, round, then accumulate, or latch the phase or sine index),
// then the plant update and the new stop check. The core takes no new beat
// while a step runs, and a result beat that waits on out_tready holds off the
// next input beat.
module pid_closed_loop_plant_step_core #(
  parameter int MAX_STEPS    = 1000,
  parameter int SINE_ENTRIES = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [0] restart
  output logic         out_tvalid,
  input  logic         out_tready,
  // [9:0] step_index, [41:10] plant_output, [73:42] loop_error,
  // [105:74] control_value, [106] settled, [107] saturated
  output logic [111:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int CW0 = $clog2(MAX_STEPS + 1);
  localparam int CW  = (CW0 > 10) ? CW0 : 10;
  localparam int IW  = $clog2(SINE_ENTRIES + 1);
  localparam int AW  = pcps_pkg::ACC_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_END  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  localparam logic [3:0] OP_KN  = 4'd0;
  localparam logic [3:0] OP_KL  = 4'd1;
  localparam logic [3:0] OP_KO  = 4'd2;
  localparam logic [3:0] OP_PH  = 4'd3;
  localparam logic [3:0] OP_IDX = 4'd4;
  localparam logic [3:0] OP_PA  = 4'd5;
  localparam logic [3:0] OP_PB  = 4'd6;
  localparam logic [3:0] OP_PC  = 4'd7;
  localparam logic [3:0] OP_PD  = 4'd8;

  // configuration registers
  logic signed [31:0] regs_r [8];

  assign cfg_pready = 1'b1;
  assign cfg_prdata = regs_r[cfg_paddr[4:2]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) regs_r[i] <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      regs_r[cfg_paddr[4:2]] <= cfg_pwdata;
    end
  end

  // loop state
  logic [2:0]          state_r;
  logic [3:0]          op_r;
  logic signed [31:0]  y_r, yp_r, e1_r, e2_r, cb_r, e_r, u_r;
  logic [CW-1:0]       count_r;
  logic                stopped_r, settled_r, sat_r, restart_r, out_valid_r;
  logic signed [AW-1:0] acc_r;
  logic [30:0]         pos_r;
  logic [1:0]          quad_r;
  logic [IW-1:0]       idx_r;

  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  prod;
  logic signed [47:0]  qprod;
  logic [16:0]         sin_raw;
  logic signed [31:0]  sin_v;

  pcps_mul u_mul (
    .clk     (clk),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .prod_r  (prod),
    .qprod_r (qprod)
  );

  pcps_sine_rom #(.ENTRIES(SINE_ENTRIES), .IW(IW)) u_rom (
    .clk    (clk),
    .addr   (idx_r),
    .data_r (sin_raw)
  );

  assign sin_v = quad_r[1] ? -$signed({15'd0, sin_raw}) : $signed({15'd0, sin_raw});

  always_comb begin
    unique case (op_r)
      OP_KN:   begin mul_a = regs_r[pcps_pkg::REG_GAIN_NOW];   mul_b = e_r;  end
      OP_KL:   begin mul_a = regs_r[pcps_pkg::REG_GAIN_LAST];  mul_b = e1_r; end
      OP_KO:   begin mul_a = regs_r[pcps_pkg::REG_GAIN_OLDER]; mul_b = e2_r; end
      OP_PH:   begin mul_a = cb_r; mul_b = pcps_pkg::INV_TWO_PI; end
      OP_IDX:  begin mul_a = $signed({1'b0, pos_r}); mul_b = 32'(SINE_ENTRIES); end
      OP_PA:   begin mul_a = regs_r[pcps_pkg::REG_PLANT_A]; mul_b = y_r;  end
      OP_PB:   begin mul_a = regs_r[pcps_pkg::REG_PLANT_B]; mul_b = yp_r; end
      OP_PC:   begin mul_a = regs_r[pcps_pkg::REG_PLANT_C]; mul_b = u_r;  end
      default: begin mul_a = regs_r[pcps_pkg::REG_PLANT_D]; mul_b = sin_v; end
    endcase
  end

  // error against setpoint, for entry check (old or reloaded y) and final check
  logic signed [31:0]   y_sel;
  logic [CW-1:0]        cnt_sel;
  pcps_pkg::sat_t       err_s;
  logic                 stop_now;
  pcps_pkg::sat_t       u_s, y_s;
  logic signed [AW-1:0] q_ext;
  logic [33:0]          idx_raw;
  logic [31:0]          ph;

  always_comb begin
    y_sel   = (state_r == ST_CHK && restart_r) ? pcps_pkg::TWO_Q : y_r;
    cnt_sel = (state_r == ST_CHK && restart_r) ? CW'(1) : count_r;
    err_s   = pcps_pkg::sat32(AW'(regs_r[pcps_pkg::REG_SETPOINT]) - AW'(y_sel));
    stop_now = (err_s.val >= -pcps_pkg::TOL_Q && err_s.val <= pcps_pkg::TOL_Q) ||
               (cnt_sel >= CW'(MAX_STEPS));
    u_s     = pcps_pkg::sat32(AW'(cb_r) + acc_r);
    y_s     = pcps_pkg::sat32(acc_r);
    q_ext   = AW'(qprod);
    idx_raw = prod[63:30];
    ph      = prod[47:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_KN;
      y_r         <= pcps_pkg::TWO_Q;
      yp_r        <= pcps_pkg::TWO_Q;
      e1_r        <= '0;
      e2_r        <= '0;
      cb_r        <= pcps_pkg::ONE_Q;
      count_r     <= CW'(1);
      stopped_r   <= 1'b0;
      settled_r   <= 1'b0;
      sat_r       <= 1'b0;
      restart_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid && in_tready) begin
            restart_r <= in_tdata[0];
            state_r   <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (restart_r) begin
            y_r         <= pcps_pkg::TWO_Q;
            yp_r        <= pcps_pkg::TWO_Q;
            cb_r        <= pcps_pkg::ONE_Q;
            e1_r        <= err_s.val;
            e2_r        <= err_s.val;
            count_r     <= CW'(1);
            stopped_r   <= stop_now;
            settled_r   <= stop_now;
            sat_r       <= err_s.clip;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else if (stopped_r || stop_now) begin
            stopped_r   <= 1'b1;
            settled_r   <= 1'b1;
            sat_r       <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else begin
            e_r     <= err_s.val;
            sat_r   <= err_s.clip;
            acc_r   <= '0;
            op_r    <= OP_KN;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          // control sum closes once the three gain products are in
          if (op_r == OP_PH) begin
            u_r   <= u_s.val;
            sat_r <= sat_r | u_s.clip;
            acc_r <= '0;
          end
          state_r <= ST_WAIT;
        end
        ST_WAIT: state_r <= ST_ACC;
        ST_ACC: begin
          unique case (op_r)
            OP_PH: begin
              quad_r <= ph[31:30];
              pos_r  <= ph[30] ? (31'h4000_0000 - {1'b0, ph[29:0]}) : {1'b0, ph[29:0]};
            end
            OP_IDX: begin
              idx_r <= (idx_raw > 34'(SINE_ENTRIES)) ? IW'(SINE_ENTRIES) : idx_raw[IW-1:0];
            end
            OP_PB:   acc_r <= acc_r - q_ext;
            default: acc_r <= acc_r + q_ext;
          endcase
          if (op_r == OP_PD) begin
            state_r <= ST_END;
          end else begin
            op_r    <= op_r + 4'd1;
            state_r <= ST_MUL;
          end
        end
        ST_END: begin
          e2_r    <= e1_r;
          e1_r    <= e_r;
          yp_r    <= y_r;
          y_r     <= y_s.val;
          cb_r    <= u_r;
          count_r <= count_r + CW'(1);
          sat_r   <= sat_r | y_s.clip;
          op_r    <= OP_KN;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          stopped_r   <= stop_now;
          settled_r   <= stop_now;
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // the result beat leaving frees the input in the same cycle
  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, sat_r, settled_r, cb_r, e1_r, y_r, count_r[9:0]};

endmodule

// ----- hw/rtl/pcps_mul.sv -----
// ----------------------------------------------------------------------------
// pcps_mul
// Shared signed 32x32 multiplier, two register stages: raw product, then the
// product rounded half up to Q32.16.
// ----------------------------------------------------------------------------
module pcps_mul (
  input  logic               clk,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [63:0] prod_r,
  output logic signed [47:0] qprod_r
);

  logic signed [63:0] prod_nxt;
  logic signed [63:0] rnd;

  assign prod_nxt = op_a * op_b;
  assign rnd      = prod_r + 64'sd32768;

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    qprod_r <= rnd[63:16];
  end

endmodule

// ----- hw/rtl/pcps_sine_rom.sv -----
// ----------------------------------------------------------------------------
// pcps_sine_rom
// Quarter-wave sine ROM, ENTRIES+1 words of unsigned Q1.16, registered read.
// ----------------------------------------------------------------------------
module pcps_sine_rom #(
  parameter int ENTRIES = 1024,
  parameter int IW      = $clog2(ENTRIES + 1)
) (
  input  logic          clk,
  input  logic [IW-1:0] addr,
  output logic [16:0]   data_r
);

  function automatic logic [63:0] term_div(input logic [63:0] v, input int j);
    logic [63:0] r;
    unique case (j)
      0: r = v / 156;
      1: r = v / 110;
      2: r = v / 72;
      3: r = v / 42;
      4: r = v / 20;
      default: r = v / 6;
    endcase
    return r;
  endfunction

  // one table word from its Taylor series, evaluated at elaboration
  function automatic logic [16:0] sine_entry(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] q30;
    q30 = 64'd1 << 30;
    x   = (64'(k) * 64'd1686629713) / 64'(ENTRIES);
    x2  = (x * x) >> 30;
    acc = q30;
    for (int j = 0; j < 6; j++) begin
      acc = q30 - term_div((x2 * acc) >> 30, j);
    end
    s = (x * acc) >> 30;
    return 17'((s + 64'd8192) >> 14);
  endfunction

  logic [16:0] rom_w [ENTRIES+1];

  for (genvar k = 0; k <= ENTRIES; k++) begin : g_rom
    localparam logic [16:0] VAL = sine_entry(k);
    assign rom_w[k] = VAL;
  end

  always_ff @(posedge clk) begin
    data_r <= rom_w[addr];
  end

endmodule

// ----- tb/sv/tb_pid_closed_loop_plant_step_core.sv -----
// ----------------------------------------------------------------------------
// tb_pid_closed_loop_plant_step_core
// Drives restart/advance beats through the closed-loop step core under
// several register settings and checks every result beat against a
// behavioral loop predictor with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_pid_closed_loop_plant_step_core;

  localparam int MAX_STEPS    = 1000;
  localparam int SINE_ENTRIES = 1024;
  localparam int DOG_LIMIT    = 2000;
  localparam int DRAIN_CYCLES = 40;

  // first field in the top bits so the cast matches out_tdata from bit 0 up
  typedef struct packed {
    logic               saturated;
    logic               settled;
    logic signed [31:0] control_value;
    logic signed [31:0] loop_error;
    logic signed [31:0] plant_output;
    logic [9:0]         step_index;
  } loop_beat_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [4:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  pid_closed_loop_plant_step_core #(
    .MAX_STEPS(MAX_STEPS), .SINE_ENTRIES(SINE_ENTRIES)
  ) i_dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic signed [31:0] regs [8];
  logic signed [31:0] y_now, y_prev, err_prev, err_older, u_prev;
  int unsigned        step_cnt;
  bit                 halted;
  logic signed [31:0] quarter_sine [SINE_ENTRIES+1];
  loop_beat_t         expected_beats [$];
  int                 fail_count = 0;
  int                 idle_pct = 6;
  int                 quiet_cycles = 0;

  function automatic void build_quarter_sine();
    longint unsigned divs [6];
    longint unsigned x, x2, t, s, q30;
    divs = '{156, 110, 72, 42, 20, 6};
    q30 = 64'd1073741824;
    for (int k = 0; k <= SINE_ENTRIES; k++) begin
      x  = (longint'(k) * 64'd1686629713) / SINE_ENTRIES;
      x2 = (x * x) >> 30;
      t  = q30;
      for (int j = 0; j < 6; j++) t = q30 - ((x2 * t) >> 30) / divs[j];
      s = (x * t) >> 30;
      quarter_sine[k] = 32'((s + 64'd8192) >> 14);
    end
  endfunction

  function automatic logic signed [31:0] clamp32(longint v, ref bit clip);
    if (v > 64'sd2147483647) begin clip = 1; return 32'sh7FFF_FFFF; end
    if (v < -64'sd2147483648) begin clip = 1; return 32'sh8000_0000; end
    return v[31:0];
  endfunction

  // exact product rounded half up to Q48.16
  function automatic longint qmul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] qsine(logic signed [31:0] u);
    longint          p;
    logic [31:0]     ph;
    longint unsigned pos, idx;
    p   = longint'(u) * longint'(pcps_pkg::INV_TWO_PI);
    ph  = p[47:16];
    pos = ph[29:0];
    if (ph[30]) pos = 64'd1073741824 - pos;
    idx = (pos * SINE_ENTRIES) >> 30;
    if (idx > SINE_ENTRIES) idx = SINE_ENTRIES;
    return ph[31] ? -quarter_sine[idx] : quarter_sine[idx];
  endfunction

  function automatic bit stop_due(ref bit clip);
    logic signed [31:0] e;
    e = clamp32(longint'(regs[pcps_pkg::REG_SETPOINT]) - longint'(y_now), clip);
    return (longint'(e) < 0 ? -longint'(e) : longint'(e)) <= pcps_pkg::TOL_Q
           || step_cnt >= MAX_STEPS;
  endfunction

  function automatic void reset_loop();
    y_now = pcps_pkg::TWO_Q; y_prev = pcps_pkg::TWO_Q; err_prev = 0; err_older = 0;
    u_prev = pcps_pkg::ONE_Q; step_cnt = 1; halted = 0;
  endfunction

  function automatic loop_beat_t predict_loop_step(bit restart);
    loop_beat_t r;
    bit clip, unused, done;
    logic signed [31:0] e, u, y;
    longint acc;
    clip = 0; unused = 0;
    if (restart) begin
      y_now = pcps_pkg::TWO_Q; y_prev = pcps_pkg::TWO_Q; u_prev = pcps_pkg::ONE_Q;
      err_prev = clamp32(longint'(regs[pcps_pkg::REG_SETPOINT])
                         - longint'(pcps_pkg::TWO_Q), clip);
      err_older = err_prev; step_cnt = 1;
      halted = stop_due(clip); done = halted;
    end else if (halted) begin
      done = 1;
    end else if (stop_due(clip)) begin
      halted = 1; done = 1; clip = 0;
    end else begin
      e = clamp32(longint'(regs[pcps_pkg::REG_SETPOINT]) - longint'(y_now), clip);
      acc = longint'(u_prev) + qmul(regs[pcps_pkg::REG_GAIN_NOW], e)
          + qmul(regs[pcps_pkg::REG_GAIN_LAST], err_prev)
          + qmul(regs[pcps_pkg::REG_GAIN_OLDER], err_older);
      u = clamp32(acc, clip);
      acc = qmul(regs[pcps_pkg::REG_PLANT_A], y_now) - qmul(regs[pcps_pkg::REG_PLANT_B], y_prev)
          + qmul(regs[pcps_pkg::REG_PLANT_C], u)
          + qmul(regs[pcps_pkg::REG_PLANT_D], qsine(u_prev));
      y = clamp32(acc, clip);
      err_older = err_prev; err_prev = e; y_prev = y_now; y_now = y; u_prev = u;
      step_cnt++;
      halted = stop_due(unused); done = halted;
    end
    r.step_index = step_cnt[9:0];
    r.plant_output = y_now;
    r.loop_error = err_prev;
    r.control_value = u_prev;
    r.settled = done;
    r.saturated = clip;
    return r;
  endfunction

  // back-to-back writes keep psel high; program_loop drops it after the last one
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    regs[idx] = val;
  endtask

  // tvalid stays up between beats; it drops only on an idle gap or a drain
  task automatic send_beat(bit restart);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_tvalid <= 1; in_tdata <= {7'd0, restart};
    do @(posedge clk); while (!in_tready);
    expected_beats.push_back(predict_loop_step(restart));
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random traffic mostly advances, with occasional restarts
  task automatic run_loop(int n);
    for (int i = 0; i < n; i++) send_beat($urandom_range(99) < 8);
  endtask

  task automatic program_loop(logic [31:0] sp, logic [31:0] k0, logic [31:0] k1,
                              logic [31:0] k2, logic [31:0] a, logic [31:0] b,
                              logic [31:0] c, logic [31:0] d);
    wait_drained();
    write_reg(pcps_pkg::REG_SETPOINT, sp);  write_reg(pcps_pkg::REG_GAIN_NOW, k0);
    write_reg(pcps_pkg::REG_GAIN_LAST, k1); write_reg(pcps_pkg::REG_GAIN_OLDER, k2);
    write_reg(pcps_pkg::REG_PLANT_A, a);    write_reg(pcps_pkg::REG_PLANT_B, b);
    write_reg(pcps_pkg::REG_PLANT_C, c);    write_reg(pcps_pkg::REG_PLANT_D, d);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic test_reset_state();
    // all registers zero: setpoint 0, y = 2, so steps proceed
    send_beat(0); send_beat(0); send_beat(1); send_beat(0);
  endtask

  task automatic test_settle_at_start();
    // setpoint equals initial output: restart reports settled
    program_loop(pcps_pkg::TWO_Q, 32'h0000_8000, 0, 0, 0, 0, 0, 0);
    send_beat(1); send_beat(0); send_beat(0);
    // just outside tolerance: restart is not settled and the steps keep y there
    program_loop(pcps_pkg::TWO_Q + 656, 0, 0, 0, pcps_pkg::ONE_Q, 0, 0, 0);
    send_beat(1); send_beat(0); send_beat(0);
  endtask

  task automatic test_saturation();
    program_loop(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(1);
    repeat (5) send_beat(0);
    program_loop(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(1);
    repeat (5) send_beat(0);
  endtask

  task automatic test_stable_loop();
    // plant that moves slowly toward the setpoint
    program_loop(32'h0005_0000, 32'h0000_4000, 32'hFFFF_E000, 32'h0000_1000,
                 32'h0000_F000, 32'h0000_0800, 32'h0000_1000, 32'h0000_2000);
    send_beat(1);
    run_loop(100);
  endtask

  task automatic test_random_settings();
    for (int s = 0; s < 6; s++) begin
      program_loop($urandom, $urandom_range(65536) - 32768, $urandom_range(16384) - 8192,
                   $urandom_range(8192) - 4096, $urandom_range(70000) - 5000,
                   $urandom_range(40000) - 20000, $urandom, $urandom);
      send_beat(1);
      run_loop(30);
    end
  endtask

  task automatic test_no_idle();
    // long stretch with both streams always ready
    idle_pct = 0;
    program_loop(32'h0064_0000, 0, 0, 0, pcps_pkg::ONE_Q, 0, 0, 0);
    send_beat(1);
    run_loop(140);
    idle_pct = 6;
  endtask

  // result checker
  always @(posedge clk) begin
    loop_beat_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = loop_beat_t'(out_tdata[107:0]);
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (got.step_index !== want.step_index) begin
            $error("step_index exp %0d got %0d", want.step_index, got.step_index);
            fail_count++;
          end
          if (got.plant_output !== want.plant_output) begin
            $error("plant_output exp %h got %h", want.plant_output, got.plant_output);
            fail_count++;
          end
          if (got.loop_error !== want.loop_error) begin
            $error("loop_error exp %h got %h", want.loop_error, got.loop_error);
            fail_count++;
          end
          if (got.control_value !== want.control_value) begin
            $error("control_value exp %h got %h", want.control_value, got.control_value);
            fail_count++;
          end
          if (got.settled !== want.settled) begin
            $error("settled exp %0b got %0b", want.settled, got.settled);
            fail_count++;
          end
          if (got.saturated !== want.saturated) begin
            $error("saturated exp %0b got %0b", want.saturated, got.saturated);
            fail_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog on accepted beats and register accesses
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > DOG_LIMIT) begin
      $display("pid_closed_loop_plant_step_core: mismatch");
      $finish;
    end
  end

  initial begin
    build_quarter_sine();
    foreach (regs[i]) regs[i] = 0;
    reset_loop();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_reset_state();
    test_settle_at_start();
    test_saturation();
    test_stable_loop();
    test_random_settings();
    test_no_idle();
    wait_drained();
    if (fail_count == 0)
      $display("pid_closed_loop_plant_step_core: match");
    else
      $display("pid_closed_loop_plant_step_core: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/pcps_pkg.sv
hw/rtl/pcps_mul.sv
hw/rtl/pcps_sine_rom.sv
hw/rtl/pid_closed_loop_plant_step_core.sv
tb/sv/tb_pid_closed_loop_plant_step_core.sv
